// File: sv/uer_pkg.sv
// ============================================================================
// uer_pkg
// Shared widths, codes and types of the ultrasonic echo ranger.
// ============================================================================
package uer_pkg;

   // Port field widths
   localparam int TS_BITS       = 32;
   localparam int RT_BITS       = 16;
   localparam int RANGE_BITS    = 18;
   localparam int IGNORE_BITS   = 10;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 18;

   // Default timestamp width used internally
   localparam int TICK_BITS_DFLT = 32;

   // Range scaling: 0.017015 cm/us in Q.8 is 1115 / 256
   localparam int RANGE_MUL   = 1115;
   localparam int MUL_BITS    = 11;
   localparam int RANGE_SHIFT = 8;

   // Register reset values
   localparam logic [RANGE_BITS-1:0]  MIN_RANGE_RST  = RANGE_BITS'(128);
   localparam logic [RANGE_BITS-1:0]  MAX_RANGE_RST  = RANGE_BITS'(102400);
   localparam logic [IGNORE_BITS-1:0] ECHO_IGNORE_RST = IGNORE_BITS'(100);

   typedef enum logic [1:0] {
      CMD_TRIGGER = 2'd0,
      CMD_ECHO    = 2'd1,
      CMD_TIMEOUT = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_GOOD      = 2'd0,
      ST_BAD_RANGE = 2'd1,
      ST_TIMEOUT   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MIN_RANGE   = 2'd0,
      CSR_MAX_RANGE   = 2'd1,
      CSR_ECHO_IGNORE = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [RANGE_BITS-1:0]  min_range;
      logic [RANGE_BITS-1:0]  max_range;
      logic [IGNORE_BITS-1:0] echo_ignore;
   } cfg_type;

endpackage

// File: sv/uer_csr.sv
// ============================================================================
// uer_csr
// Configuration registers: range window and echo blanking time.
// ============================================================================
module uer_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [uer_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output uer_pkg::cfg_type                    cfg
);
   import uer_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always able to take a write beat
   assign csr_ready = 1'b1;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MIN_RANGE:   cfg_in.min_range   = csr_wdata[RANGE_BITS-1:0];
            CSR_MAX_RANGE:   cfg_in.max_range   = csr_wdata[RANGE_BITS-1:0];
            CSR_ECHO_IGNORE: cfg_in.echo_ignore = csr_wdata[IGNORE_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_range   <= MIN_RANGE_RST;
         cfg_ff.max_range   <= MAX_RANGE_RST;
         cfg_ff.echo_ignore <= ECHO_IGNORE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/ultrasonic_echo_ranger.sv
// ============================================================================
// ultrasonic_echo_ranger
// Echo timing of an ultrasonic ranger from timestamped pin edge events.
// ============================================================================
// Path: an accepted req beat goes into the input register, then one update pass
//   through the range multiply and window compare commits it to the rsp beat.
// Throughput: 1 item per cycle while rsp is not stalled; every item gives exactly one rsp beat.
// Reset: synchronous; clears the pipeline, the reading state and the stored
//   reading, and loads the configuration register defaults.
// ============================================================================
module ultrasonic_echo_ranger #(
   parameter int TICK_BITS = uer_pkg::TICK_BITS_DFLT
) (
   input  logic                               clock,
   input  logic                               reset,
   // event channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_cmd,
   input  logic                               req_echo_level,
   input  logic [uer_pkg::TS_BITS-1:0]        req_tick_us,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_reading_done,
   output logic [1:0]                         rsp_status,
   output logic [uer_pkg::RT_BITS-1:0]        rsp_round_trip_us,
   output logic [uer_pkg::RANGE_BITS-1:0]     rsp_range_cm_q8,
   output logic                               rsp_ready_res,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [uer_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import uer_pkg::*;

   localparam int PROD_BITS   = TICK_BITS + MUL_BITS;
   localparam int SCALED_BITS = PROD_BITS - RANGE_SHIFT;

   cfg_type cfg;

   // Handshake
   logic out_free;
   logic advance;
   logic req_take;

   // Input stage
   logic                 s1_valid_ff, s1_valid_in;
   cmd_type              s1_cmd_ff;
   logic                 s1_level_ff;
   logic [TICK_BITS-1:0] s1_tick_ff;

   // Ranger state (also the held result fields)
   logic                  armed_ff, armed_in;
   logic                  echo_high_ff, echo_high_in;
   logic [TICK_BITS-1:0]  trig_time_ff, trig_time_in;
   logic [TICK_BITS-1:0]  echo_start_ff, echo_start_in;
   logic                  ready_ff, ready_in;
   logic                  new_reading_ff, new_reading_in;
   status_type            status_ff, status_in;
   logic [RT_BITS-1:0]    last_rt_ff, last_rt_in;
   logic [RANGE_BITS-1:0] last_range_ff, last_range_in;
   logic                  done_ff, done_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Datapath
   logic [TICK_BITS-1:0]   trig_diff;
   logic                   echo_ok;
   logic [TICK_BITS-1:0]   round_trip;
   logic [PROD_BITS-1:0]   product;
   logic [SCALED_BITS-1:0] scaled;
   logic                   in_window;

   uer_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Flow control: the input stage moves on whenever the result slot frees up
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = s1_valid_ff && out_free;
   assign req_stall    = s1_valid_ff && !out_free;
   assign req_take     = req_valid && !req_stall;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff   <= cmd_type'(req_cmd);
         s1_level_ff <= req_echo_level;
         s1_tick_ff  <= req_tick_us[TICK_BITS-1:0];
      end
   end

   // Echo qualification: positive difference beyond the blanking time
   assign trig_diff = s1_tick_ff - trig_time_ff;
   assign echo_ok   = !trig_diff[TICK_BITS-1] &&
                      (trig_diff > TICK_BITS'(cfg.echo_ignore));

   // Round trip to range in 1/256 cm
   assign round_trip = s1_tick_ff - echo_start_ff;
   assign product    = PROD_BITS'(round_trip) * PROD_BITS'(RANGE_MUL);
   assign scaled     = product[PROD_BITS-1:RANGE_SHIFT];
   assign in_window  = (SCALED_BITS'(cfg.min_range) <= scaled) &&
                       (scaled <= SCALED_BITS'(cfg.max_range));

   // Event update
   always_comb begin
      armed_in       = armed_ff;
      echo_high_in   = echo_high_ff;
      trig_time_in   = trig_time_ff;
      echo_start_in  = echo_start_ff;
      ready_in       = ready_ff;
      new_reading_in = new_reading_ff;
      status_in      = status_ff;
      last_rt_in     = last_rt_ff;
      last_range_in  = last_range_ff;
      done_in        = 1'b0;
      unique case (s1_cmd_ff)
         CMD_TRIGGER: begin
            armed_in       = 1'b1;
            trig_time_in   = s1_tick_ff;
            echo_high_in   = 1'b0;
            new_reading_in = 1'b0;
         end
         CMD_ECHO: begin
            if (s1_level_ff) begin
               // a later qualifying rising edge restarts the echo
               if (armed_ff && echo_ok) begin
                  echo_high_in  = 1'b1;
                  echo_start_in = s1_tick_ff;
               end
            end else if (echo_high_ff) begin
               echo_high_in   = 1'b0;
               armed_in       = 1'b0;
               ready_in       = 1'b1;
               new_reading_in = 1'b1;
               done_in        = 1'b1;
               if (in_window) begin
                  last_range_in = scaled[RANGE_BITS-1:0];
                  last_rt_in    = round_trip[RT_BITS-1:0];
                  status_in     = ST_GOOD;
               end else begin
                  status_in = ST_BAD_RANGE;
               end
            end
         end
         CMD_TIMEOUT: begin
            // only when no reading followed the last trigger
            if (!new_reading_ff) begin
               status_in = ST_TIMEOUT;
               ready_in  = 1'b1;
               done_in   = 1'b1;
            end
         end
         CMD_READ: begin
            ready_in = 1'b0;
         end
         default: begin
            ready_in = ready_ff;
         end
      endcase
   end

   // State commits together with the result beat; held while rsp stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         echo_high_ff   <= 1'b0;
         ready_ff       <= 1'b0;
         new_reading_ff <= 1'b0;
         status_ff      <= ST_GOOD;
         last_rt_ff     <= '0;
         last_range_ff  <= '0;
         done_ff        <= 1'b0;
      end else if (advance) begin
         armed_ff       <= armed_in;
         echo_high_ff   <= echo_high_in;
         ready_ff       <= ready_in;
         new_reading_ff <= new_reading_in;
         status_ff      <= status_in;
         last_rt_ff     <= last_rt_in;
         last_range_ff  <= last_range_in;
         done_ff        <= done_in;
      end
   end

   // Timestamps only matter once armed or echo high
   always_ff @(posedge clock) begin
      if (advance) begin
         trig_time_ff  <= trig_time_in;
         echo_start_ff <= echo_start_in;
      end
   end

   // Result beat
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reading_done  = done_ff;
   assign rsp_status        = status_ff;
   assign rsp_round_trip_us = last_rt_ff;
   assign rsp_range_cm_q8   = last_range_ff;
   assign rsp_ready_res     = ready_ff;

endmodule

// File: tb/ultrasonic_echo_ranger_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// ultrasonic_echo_ranger_tb
// Self-checking bench for the echo ranger. A table of pin events covers the
// corner cases first. Random trigger/echo sequences then run under several
// range windows. Every result beat is checked field by field against an
// in-bench echo timing model; the first table rows use fixed expected readings.
// ============================================================================
module ultrasonic_echo_ranger_tb;
   import uer_pkg::*;

   localparam int SETTLE_CYCLES = 4;          // settle time after the last expected beat
   localparam int HOLD_CYCLES   = 60;         // long receiver hold-off
   localparam int PHASE_EVENTS  = 185;
   localparam int RUN_LIMIT_NS  = 6_000_000;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;   // no register here

   typedef struct packed {
      logic                  done;
      status_type            status;
      logic [RT_BITS-1:0]    round_trip;
      logic [RANGE_BITS-1:0] range_q8;
      logic                  ready;
   } reading_type;

   typedef struct {
      cmd_type            cmd;
      logic               level;
      logic [TS_BITS-1:0] tick;
      bit                 typed;
      reading_type        want;
   } plan_row_type;

   // Results that can be read straight off the event
   localparam reading_type NO_WANT       = '0;
   localparam reading_type AFTER_RESET   = '{1'b0, ST_GOOD, 16'd0, 18'd0, 1'b0};
   localparam reading_type FIRST_TIMEOUT = '{1'b1, ST_TIMEOUT, 16'd0, 18'd0, 1'b1};
   localparam reading_type TIMEOUT_READ  = '{1'b0, ST_TIMEOUT, 16'd0, 18'd0, 1'b0};

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_cmd        = '0;
   logic                     req_echo_level = 1'b0;
   logic [TS_BITS-1:0]       req_tick_us    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic                     rsp_reading_done;
   logic [1:0]               rsp_status;
   logic [RT_BITS-1:0]       rsp_round_trip_us;
   logic [RANGE_BITS-1:0]    rsp_range_cm_q8;
   logic                     rsp_ready_res;
   logic                     csr_valid      = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index      = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata      = '0;

   // Echo timing model state
   cfg_type               win;
   logic                  armed, echo_high, ready_flag, new_reading;
   logic [TS_BITS-1:0]    trigger_at, echo_start_at;
   status_type            held_status;
   logic [RT_BITS-1:0]    held_round_trip;
   logic [RANGE_BITS-1:0] held_range;

   reading_type        expected_readings[$];
   logic [TS_BITS-1:0] now_us;
   int                 send_idle_pct = 0;
   int                 stall_pct     = 0;
   logic               hold_req      = 1'b0;
   int                 faults        = 0;
   int                 events        = 0;
   int                 beats         = 0;
   int                 windows       = 1;
   int                 good_count    = 0;
   int                 bad_count     = 0;
   int                 timeout_count = 0;
   plan_row_type       plan [26];

   ultrasonic_echo_ranger dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Model: apply one event, return the result beat it should produce
   function automatic reading_type time_echo(input cmd_type cmd, input logic level,
                                             input logic [TS_BITS-1:0] tick);
      logic [TS_BITS-1:0] gap;
      logic [63:0]        range_full;
      reading_type        r;
      r.done = 1'b0;
      case (cmd)
         CMD_TRIGGER: begin
            armed       = 1'b1;
            trigger_at  = tick;
            echo_high   = 1'b0;
            new_reading = 1'b0;
         end
         CMD_ECHO: begin
            if (level) begin
               // only a positive gap past the blanking time starts the echo
               gap = tick - trigger_at;
               if (armed && !gap[TS_BITS-1] && gap > TS_BITS'(win.echo_ignore)) begin
                  echo_high     = 1'b1;
                  echo_start_at = tick;
               end
            end else if (echo_high) begin
               gap        = tick - echo_start_at;
               range_full = (64'(gap) * 64'(RANGE_MUL)) >> RANGE_SHIFT;
               echo_high  = 1'b0;
               armed      = 1'b0;
               if (64'(win.min_range) <= range_full && range_full <= 64'(win.max_range)) begin
                  held_range      = range_full[RANGE_BITS-1:0];
                  held_round_trip = gap[RT_BITS-1:0];
                  held_status     = ST_GOOD;
                  good_count++;
               end else begin
                  held_status = ST_BAD_RANGE;
                  bad_count++;
               end
               ready_flag  = 1'b1;
               new_reading = 1'b1;
               r.done      = 1'b1;
            end
         end
         CMD_TIMEOUT: begin
            if (!new_reading) begin
               held_status = ST_TIMEOUT;
               ready_flag  = 1'b1;
               r.done      = 1'b1;
               timeout_count++;
            end
         end
         default: begin
            ready_flag = 1'b0;
         end
      endcase
      r.status     = held_status;
      r.round_trip = held_round_trip;
      r.range_q8   = held_range;
      r.ready      = ready_flag;
      return r;
   endfunction

   // Offer one event beat; called and returning at a falling edge
   task automatic offer_event(input cmd_type cmd, input logic level,
                              input logic [TS_BITS-1:0] tick,
                              input bit typed, input reading_type want);
      reading_type modeled;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(8, 1)) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_cmd        = cmd;
      req_echo_level = level;
      req_tick_us    = tick;
      do @(posedge clock); while (req_stall);
      modeled = time_echo(cmd, level, tick);
      expected_readings.push_back(typed ? want : modeled);
      events++;
      @(negedge clock);
   endtask

   task automatic fire(input cmd_type cmd, input logic level,
                       input logic [TS_BITS-1:0] tick);
      offer_event(cmd, level, tick, 1'b0, NO_WANT);
   endtask

   // Stop sending and let every expected beat come out
   task automatic drain_results();
      req_valid = 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the three registers, and the unused index if asked, with the block idle
   task automatic load_window(input logic [CSR_DATA_BITS-1:0] min_word,
                              input logic [CSR_DATA_BITS-1:0] max_word,
                              input logic [CSR_DATA_BITS-1:0] ignore_word,
                              input bit poke_spare);
      logic [CSR_IDX_BITS-1:0]  idx  [4];
      logic [CSR_DATA_BITS-1:0] word [4];
      int                       n;
      idx  = '{CSR_MIN_RANGE, CSR_MAX_RANGE, CSR_ECHO_IGNORE, CSR_SPARE};
      word = '{min_word, max_word, ignore_word, CSR_DATA_BITS'($urandom)};
      n    = poke_spare ? 4 : 3;
      drain_results();
      for (int k = 0; k < n; k++) begin
         csr_valid = 1'b1;
         csr_index = idx[k];
         csr_wdata = word[k];
         do @(posedge clock); while (!csr_ready);
         case (idx[k])
            CSR_MIN_RANGE:   win.min_range   = word[k];
            CSR_MAX_RANGE:   win.max_range   = word[k];
            CSR_ECHO_IGNORE: win.echo_ignore = word[k][IGNORE_BITS-1:0];
            default: ;
         endcase
         @(negedge clock);
      end
      csr_valid = 1'b0;
      windows++;
   endtask

   // Mostly complete trigger/echo sequences with random timing, plus noise
   task automatic run_echo_traffic(input int count);
      int                    stop_at;
      int                    pick;
      logic [TS_BITS-1:0]    trig, rise, trip;
      logic [RANGE_BITS-1:0] target;
      stop_at = events + count;
      while (events < stop_at) begin
         pick = $urandom_range(9);
         if (pick <= 6) begin
            now_us += $urandom_range(5000, 1);
            trig = now_us;
            fire(CMD_TRIGGER, 1'($urandom), trig);
            if ($urandom_range(3) == 0) begin
               fire(CMD_ECHO, 1'b1, trig + $urandom_range(win.echo_ignore, 0));
            end
            rise = trig + win.echo_ignore + $urandom_range(2000, 1);
            fire(CMD_ECHO, 1'b1, rise);
            if ($urandom_range(4) == 0) begin
               rise += $urandom_range(300);
               fire(CMD_ECHO, 1'b1, rise);
            end
            // mostly aim inside the window, sometimes well outside it
            case ($urandom_range(9))
               7: trip = $urandom_range(40);
               8: trip = $urandom_range(65535);
               9: trip = $urandom;
               default: begin
                  target = RANGE_BITS'($urandom_range(win.max_range, win.min_range));
                  trip = (TS_BITS'(target) << RANGE_SHIFT) / RANGE_MUL + $urandom_range(1);
               end
            endcase
            now_us = rise + trip;
            fire(CMD_ECHO, 1'b0, now_us);
            if ($urandom_range(2) == 0) begin
               fire(CMD_TIMEOUT, 1'($urandom), now_us + $urandom_range(100));
            end
            if ($urandom_range(1) == 0) begin
               fire(CMD_READ, 1'($urandom), now_us + $urandom_range(100));
            end
         end else if (pick == 7) begin
            fire(cmd_type'($urandom_range(3)), 1'($urandom), $urandom);
         end else if (pick == 8) begin
            // trigger that never sees a full echo
            now_us += $urandom_range(5000, 1);
            fire(CMD_TRIGGER, 1'b0, now_us);
            if ($urandom_range(1) == 0) begin
               fire(CMD_ECHO, 1'b0, now_us + $urandom_range(3000));
            end
            fire(CMD_TIMEOUT, 1'($urandom), now_us + 30000);
            if ($urandom_range(1) == 0) begin
               fire(CMD_ECHO, 1'b1, now_us + win.echo_ignore + $urandom_range(500, 1));
            end
         end else begin
            fire(cmd_type'($urandom_range(3, 2)), 1'($urandom), now_us);
         end
      end
   endtask

   // Result checker
   always @(posedge clock) begin : check_results
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            $error("result beat with no event waiting for it");
            faults++;
         end else begin
            want = expected_readings.pop_front();
            beats++;
            if (rsp_reading_done !== want.done) begin
               $error("reading_done: expected %0d, got %0d", want.done, rsp_reading_done);
               faults++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               faults++;
            end
            if (rsp_round_trip_us !== want.round_trip) begin
               $error("round_trip_us: expected %0d, got %0d", want.round_trip,
                      rsp_round_trip_us);
               faults++;
            end
            if (rsp_range_cm_q8 !== want.range_q8) begin
               $error("range_cm_q8: expected %0d, got %0d", want.range_q8, rsp_range_cm_q8);
               faults++;
            end
            if (rsp_ready_res !== want.ready) begin
               $error("ready_res: expected %0d, got %0d", want.ready, rsp_ready_res);
               faults++;
            end
         end
      end
   end

   // Receiver: random stall bursts, or one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req  = 1'b0;
            rsp_stall = 1'b0;
         end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(8, 1)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // Run limit
   initial begin
      #(RUN_LIMIT_NS);
      $error("run limit reached with %0d beats outstanding", expected_readings.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      win             = '{MIN_RANGE_RST, MAX_RANGE_RST, ECHO_IGNORE_RST};
      armed           = 1'b0;
      echo_high       = 1'b0;
      ready_flag      = 1'b0;
      new_reading     = 1'b0;
      trigger_at      = '0;
      echo_start_at   = '0;
      held_status     = ST_GOOD;
      held_round_trip = '0;
      held_range      = '0;

      // Corner cases at the reset window (0.5 cm .. 400 cm, 100 us blanking)
      plan[0]  = '{CMD_READ,    1'b0, 32'd0,          1'b1, AFTER_RESET};
      plan[1]  = '{CMD_TIMEOUT, 1'b0, 32'd5,          1'b1, FIRST_TIMEOUT};
      plan[2]  = '{CMD_READ,    1'b0, 32'd6,          1'b1, TIMEOUT_READ};
      plan[3]  = '{CMD_ECHO,    1'b1, 32'd10,         1'b1, TIMEOUT_READ};  // rise, not armed
      plan[4]  = '{CMD_ECHO,    1'b0, 32'd20,         1'b1, TIMEOUT_READ};  // fall, no echo
      plan[5]  = '{CMD_TRIGGER, 1'b0, 32'd1000,       1'b1, TIMEOUT_READ};
      plan[6]  = '{CMD_ECHO,    1'b1, 32'd1050,       1'b0, NO_WANT};       // inside blanking
      plan[7]  = '{CMD_ECHO,    1'b1, 32'd1100,       1'b0, NO_WANT};       // exactly at it
      plan[8]  = '{CMD_ECHO,    1'b1, 32'd1101,       1'b0, NO_WANT};
      plan[9]  = '{CMD_ECHO,    1'b1, 32'd1200,       1'b0, NO_WANT};       // restart
      plan[10] = '{CMD_ECHO,    1'b0, 32'd6200,       1'b0, NO_WANT};
      plan[11] = '{CMD_TIMEOUT, 1'b0, 32'd6300,       1'b0, NO_WANT};       // after a reading
      plan[12] = '{CMD_READ,    1'b0, 32'd6400,       1'b0, NO_WANT};
      plan[13] = '{CMD_TRIGGER, 1'b0, 32'hFFFF_FF00,  1'b0, NO_WANT};
      plan[14] = '{CMD_ECHO,    1'b1, 32'h0000_0100,  1'b0, NO_WANT};       // across the wrap
      plan[15] = '{CMD_ECHO,    1'b0, 32'h0000_EB60,  1'b0, NO_WANT};       // beyond max
      plan[16] = '{CMD_TRIGGER, 1'b1, 32'd5000,       1'b0, NO_WANT};
      plan[17] = '{CMD_ECHO,    1'b1, 32'd4000,       1'b0, NO_WANT};       // before trigger
      plan[18] = '{CMD_ECHO,    1'b1, 32'h8000_1388,  1'b0, NO_WANT};       // gap reads negative
      plan[19] = '{CMD_TIMEOUT, 1'b1, 32'd5100,       1'b0, NO_WANT};
      plan[20] = '{CMD_ECHO,    1'b1, 32'd5200,       1'b0, NO_WANT};       // still armed
      plan[21] = '{CMD_ECHO,    1'b0, 32'd5200,       1'b0, NO_WANT};       // zero round trip
      plan[22] = '{CMD_TRIGGER, 1'b0, 32'hFFFF_FFFF,  1'b0, NO_WANT};
      plan[23] = '{CMD_ECHO,    1'b1, 32'h7FFF_FFFE,  1'b0, NO_WANT};       // largest positive gap
      plan[24] = '{CMD_ECHO,    1'b0, 32'h7FFF_FFFD,  1'b0, NO_WANT};       // full-width trip
      plan[25] = '{CMD_READ,    1'b1, 32'hFFFF_FFFF,  1'b0, NO_WANT};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 25;
      stall_pct     = 25;
      foreach (plan[k]) begin
         offer_event(plan[k].cmd, plan[k].level, plan[k].tick, plan[k].typed, plan[k].want);
      end

      now_us = $urandom;

      // widest window, no blanking
      send_idle_pct = 20;
      stall_pct     = 20;
      load_window(18'd128, 18'd255999, 18'd0, 1'b0);
      run_echo_traffic(PHASE_EVENTS);

      // narrowest window at the top, longest blanking, full rate
      send_idle_pct = 0;
      stall_pct     = 0;
      load_window(18'd255998, 18'd255999, 18'd1023, 1'b0);
      run_echo_traffic(PHASE_EVENTS);

      // crossed window: every reading is out of range; unused index poked
      send_idle_pct = 35;
      stall_pct     = 35;
      load_window(18'd200000, 18'd1000, 18'd500, 1'b1);
      run_echo_traffic(PHASE_EVENTS);

      // random window, junk above the blanking field, long receiver hold-off
      send_idle_pct = 15;
      stall_pct     = 15;
      win.min_range = RANGE_BITS'($urandom_range(120000, 128));
      load_window(win.min_range, CSR_DATA_BITS'($urandom_range(255999, win.min_range + 1)),
                  {8'($urandom), 10'($urandom)}, 1'b0);
      hold_req = 1'b1;
      run_echo_traffic(PHASE_EVENTS);

      // reset values again, no idling to the end
      send_idle_pct = 0;
      stall_pct     = 0;
      load_window(MIN_RANGE_RST, MAX_RANGE_RST, CSR_DATA_BITS'(ECHO_IGNORE_RST), 1'b0);
      run_echo_traffic(PHASE_EVENTS);

      drain_results();
      $display("Covered %0d pin events over %0d window settings, %0d result beats checked.",
               events, windows, beats);
      $display("Readings in window %0d, out of window %0d, timeouts %0d.",
               good_count, bad_count, timeout_count);
      if (faults == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/uer_pkg.sv
sv/uer_csr.sv
sv/ultrasonic_echo_ranger.sv
tb/ultrasonic_echo_ranger_tb.sv
